[rtl/aes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Shared constants, types and byte functions for the AES-128 encryptor.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int unsigned NUM_ROUNDS = 10;
   localparam int unsigned NUM_STAGES = NUM_ROUNDS + 1;
   localparam int unsigned STG_W      = $clog2(NUM_STAGES + 1);

   // Configuration register indexes.
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   typedef logic [127:0] block_type;

   // Forward S-box.
   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] tab [256];
      tab = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return tab[x];
   endfunction

   // Round constant for the key word that opens round r (1..10).
   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a block: byte 0 is the most significant byte.
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   // SubBytes and ShiftRows together.
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = sbox(get_byte(s, 4*((c + r) % 4) + r));
         end
      end
      return t;
   endfunction

   function automatic block_type mix_cols(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c + 1);
         a2 = get_byte(s, 4*c + 2);
         a3 = get_byte(s, 4*c + 3);
         b0 = xtime(a0);
         b1 = xtime(a1);
         b2 = xtime(a2);
         b3 = xtime(a3);
         t[127 - 32*c -: 32] = {b0 ^ a1 ^ b1 ^ a2 ^ a3, a0 ^ b1 ^ a2 ^ b2 ^ a3,
                                a0 ^ a1 ^ b2 ^ a3 ^ b3, a0 ^ b0 ^ a1 ^ a2 ^ b3};
      end
      return t;
   endfunction

   // Next round key from the previous one.
   function automatic block_type next_key(input block_type k, input logic [3:0] r);
      block_type n;
      logic [31:0] t;
      logic [31:0] w3;
      w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      n[127:96] = k[127:96] ^ t;
      n[95:64]  = k[95:64] ^ n[127:96];
      n[63:32]  = k[63:32] ^ n[95:64];
      n[31:0]   = k[31:0] ^ n[63:32];
      return n;
   endfunction

endpackage

[rtl/aes128_block_encrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 ECB block encryptor
// Unrolled round pipeline: one 128-bit block per cycle, key from two registers.
// ----------------------------------------------------------------------------
// Accepts one plaintext block per clock. The ciphertext shows on rsp_tvalid
// once the block has passed through every register stage. There are eleven
// register stages: stage 0 does the initial key addition, and stages 1 to 10
// each do one AES round. Each round stage expands its own round key alongside
// the data, so the latency is set by the ten unrolled rounds plus the entry
// stage. Each block takes the key as it is in the registers on the cycle it
// is accepted. Back-pressure on rsp_tready stalls the whole pipeline without
// loss.
module aes128_block_encrypt
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // plain_high [63:0], plain_low [127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // cipher_high [63:0], cipher_low [127:64]
);

   logic [63:0] key_high_ff, key_low_ff;
   logic [NUM_STAGES-1:0] vld_ff;
   block_type state_ff [NUM_STAGES];
   block_type rkey_ff  [NUM_STAGES];
   logic adv;

   // Pipeline advances when the last stage is empty or being taken.
   assign adv        = !vld_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = {state_ff[NUM_STAGES-1][63:0], state_ff[NUM_STAGES-1][127:64]};

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_tvalid};
      end
   end

   // Entry stage: initial key addition.
   always_ff @(posedge clock) begin
      if (adv) begin
         state_ff[0] <= {req_tdata[63:0] ^ key_high_ff, req_tdata[127:64] ^ key_low_ff};
         rkey_ff[0]  <= {key_high_ff, key_low_ff};
      end
   end

   // Round stages; the last one skips column mixing.
   for (genvar g = 1; g < NUM_STAGES; g++) begin : g_round
      block_type rk_in, st_in;
      always_comb begin
         rk_in = next_key(rkey_ff[g-1], 4'(g));
         if (g == NUM_STAGES - 1) begin
            st_in = sub_shift(state_ff[g-1]) ^ rk_in;
         end else begin
            st_in = mix_cols(sub_shift(state_ff[g-1])) ^ rk_in;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            state_ff[g] <= st_in;
            rkey_ff[g]  <= rk_in;
         end
      end
   end

endmodule

[rtl/aes128_block_encrypt_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES encryptor port checker
// Port-level checks of the stream handshakes and of the output after reset.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_chk (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   // A stalled response holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // An idle or draining output never blocks requests.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request blocked with free output");

   // A stalled output blocks requests.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken during stall");

   // Nothing comes out right after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind aes128_block_encrypt aes128_block_encrypt_chk u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

[tb/tb_aes128_block_encrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 ECB encryptor testbench
// Drives plaintext requests with random gaps and random back-pressure, keeps
// its own AES-128 cipher to predict each ciphertext, and compares every
// response in order. The key is changed between phases while the pipe is idle.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt;
   import aes_pkg::*;

   localparam int PIPE_LATENCY = 12;
   localparam int STALL_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 1800;

   // Scoreboard: holds the predicted ciphertexts in request order.
   class cipher_scoreboard;
      logic [127:0] pending[$];
      int           mismatches;
      int           checked;

      function void note_request(logic [127:0] ct);
         pending.push_back(ct);
      endfunction

      function void check_response(logic [127:0] got);
         logic [127:0] want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response %h", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got[127:64] !== want[127:64] || got[63:0] !== want[63:0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: cipher_high exp %h got %h, cipher_low exp %h got %h",
                        want[127:64], got[127:64], want[63:0], got[63:0]);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic         csr_index;
   logic [63:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;

   cipher_scoreboard board;
   logic [63:0] key_hi_q;
   logic [63:0] key_lo_q;
   int          idle_cycles;
   int          sent;
   bit          long_stall;
   bit          timed_out;

   aes128_block_encrypt dut (.*);

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // S-box built from its definition: multiplicative inverse then affine map.
   logic [7:0] sub_tab [256];

   function automatic logic [7:0] gf_dbl(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_dbl(a);
      end
      return p;
   endfunction

   task automatic build_sub_table();
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++)
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         s = 8'h63;
         for (int i = 0; i < 8; i++)
            s[i] = s[i] ^ inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8]
                   ^ inv[(i + 6) % 8] ^ inv[(i + 7) % 8];
         sub_tab[x] = s;
      end
   endtask

   // Full AES-128 encryption; byte 0 is the top byte, bytes column-major.
   function automatic logic [127:0] encrypt(logic [127:0] key, logic [127:0] pt);
      logic [7:0] rk [11][16];
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] w [4];
      logic [7:0] rc, first, a0, a1, a2, a3;
      logic [127:0] ct;
      for (int i = 0; i < 16; i++) begin
         rk[0][i] = key[127 - 8*i -: 8];
         st[i]    = pt[127 - 8*i -: 8] ^ rk[0][i];
      end
      rc = 8'h01;
      for (int r = 1; r <= 10; r++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[r-1][12 + j];
         first = w[0];
         w[0] = sub_tab[w[1]] ^ rc;
         w[1] = sub_tab[w[2]];
         w[2] = sub_tab[w[3]];
         w[3] = sub_tab[first];
         rc = gf_dbl(rc);
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) begin
               rk[r][4*c + j] = rk[r-1][4*c + j] ^ w[j];
               w[j] = rk[r][4*c + j];
            end
      end
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
               tmp[4*c + j] = sub_tab[st[4*((c + j) % 4) + j]];
         if (r < 10)
            for (int c = 0; c < 4; c++) begin
               a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
               tmp[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
               tmp[4*c+1] = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
               tmp[4*c+2] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
               tmp[4*c+3] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
            end
         for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[r][i];
      end
      for (int i = 0; i < 16; i++) ct[127 - 8*i -: 8] = st[i];
      return ct;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random half with a bias toward all-zero and all-one patterns.
   function automatic logic [63:0] pick64();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return rand64();
      endcase
   endfunction

   task automatic write_key(logic [63:0] hi, logic [63:0] lo);
      csr_we <= 1'b1; csr_index <= CSR_KEY_HIGH; csr_wdata <= hi;
      @(negedge clock);
      csr_index <= CSR_KEY_LOW; csr_wdata <= lo;
      @(negedge clock);
      csr_we <= 1'b0;
      key_hi_q = hi;
      key_lo_q = lo;
   endtask

   // Offers one request, optionally after a random gap, and waits for accept.
   // The block is given high half first; on the bus it sits in the low bits.
   task automatic send_block(logic [127:0] pt, bit gaps);
      int wait_n;
      wait_n = gaps ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      if (wait_n > 0) begin
         req_tvalid <= 1'b0;
         repeat (wait_n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pt[63:0], pt[127:64]};
      do @(posedge clock); while (!req_tready);
      board.note_request(encrypt({key_hi_q, key_lo_q}, pt));
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0 && !timed_out) @(negedge clock);
      repeat (PIPE_LATENCY) @(negedge clock);
   endtask

   // Response sampling; cipher_high sits in the low bits of the bus.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response({rsp_tdata[63:0], rsp_tdata[127:64]});

   // Receiver back-pressure: random per-item stalls, one long hold-off.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_stall) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            long_stall = 0;
         end
         else if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end
         else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog on cycles without any accepted request or response.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         timed_out = 1;
         $display("tb_aes128_block_encrypt NOT OK");
         $finish;
      end
   end

   initial begin
      board = new();
      reset = 1'b1; csr_we = 1'b0; csr_index = CSR_KEY_HIGH; csr_wdata = '0;
      req_tvalid = 1'b0; req_tdata = '0;
      key_hi_q = '0; key_lo_q = '0;
      idle_cycles = 0; sent = 0; long_stall = 0; timed_out = 0;
      build_sub_table();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset key (all zero) with extreme plaintexts.
      send_block('0, 0);
      send_block('1, 0);
      drain();

      // Published FIPS-197 vector, then extreme keys and walking bits.
      write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(128'h00112233445566778899aabbccddeeff, 0);
      send_block({64'h8000000000000000, 64'h0000000000000001}, 1);
      send_block({64'h0, 64'hffffffffffffffff}, 0);
      drain();
      write_key('1, '1);
      send_block('0, 0);
      send_block('1, 0);
      for (int b = 0; b < 128; b += 9) send_block(128'd1 << b, 1);
      drain();

      // Random phases: new key each phase, one phase with a long hold-off.
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 11) write_key('0, '0);
         else write_key(pick64(), pick64());
         if (ph == 3) long_stall = 1;
         for (int i = 0; i < RANDOM_ITEMS / 12; i++)
            send_block({pick64(), pick64()}, ph != 3);
         drain();
      end

      $display("Encrypted %0d blocks under 15 keys, %0d responses compared.",
               sent, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("tb_aes128_block_encrypt OK");
      else
         $display("tb_aes128_block_encrypt NOT OK");
      $finish;
   end

endmodule
